/* design/crsf_frame_parser_top_defines.svh */
// ----------------------------------------------------------------------------
// crsf_frame_parser_top_defines.svh
// Assertion macros used by the frame parser datapath.
// ----------------------------------------------------------------------------
`ifndef CRSF_FRAME_PARSER_TOP_DEFINES_SVH
`define CRSF_FRAME_PARSER_TOP_DEFINES_SVH

`ifndef SYNTH
// Condition holds at every clock edge outside reset.
`define CFP_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define CFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CFP_ASSERT(lbl, cond, msg)
`define CFP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* design/cfp_pkg.sv */
// ----------------------------------------------------------------------------
// cfp_pkg
// Types, constants and helper functions of the frame parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam int MaxLengthField = 64;
  localparam int BufDepth       = MaxLengthField + 2;
  localparam int PtrW           = $clog2(BufDepth + 1);

  localparam logic [7:0] CrcPoly     = 8'hD5;
  localparam logic [7:0] TypeLink    = 8'h14;
  localparam logic [7:0] TypeChannel = 8'h16;
  localparam logic [7:0] TypeBattery = 8'h08;

  localparam logic [PtrW-1:0] LinkNeed = PtrW'(4);
  localparam logic [PtrW-1:0] BattNeed = PtrW'(8);
  localparam logic [PtrW-1:0] ChanNeed = PtrW'(22);

  typedef enum logic [1:0] {
    KIND_LINK      = 2'd0,
    KIND_CHAN      = 2'd1,
    KIND_CHAN_LAST = 2'd2,
    KIND_BATT      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    DEC_NONE,
    DEC_LINK,
    DEC_CHAN,
    DEC_BATT
  } dec_t;

  typedef enum logic [2:0] {
    RD_LEN,
    RD_CRC,
    RD_CHK,
    RD_ADDR,
    RD_TYPE,
    RD_PAY
  } rd_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_LEN_CHK,
    S_CRC_RD,
    S_CRC_ACC,
    S_CHK_RD,
    S_CHK_CMP,
    S_ADDR_GET,
    S_TYPE_GET,
    S_DEC,
    S_PAY_RD,
    S_PAY_GET,
    S_PAY_NEXT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic    append;
    rd_sel_t rd_sel;
    logic    drop1;
    logic    drop_frame;
    logic    len_load;
    logic    cnt_clr;
    logic    crc_acc;
    logic    cnt_inc;
    logic    addr_load;
    logic    type_load;
    logic    pay_load;
    logic    emit;
  } cfp_cmd_t;

  typedef struct packed {
    logic fill_ge4;
    logic len_bad;
    logic len_short;
    logic crc_last;
    logic crc_ok;
    dec_t dec;
    logic pay_done;
    logic ch_avail;
    logic out_free;
  } cfp_stat_t;

  // Fold a sum below twice the depth back into the circular buffer.
  function automatic logic [PtrW-1:0] cfp_wrap(input logic [PtrW:0] s);
    logic [PtrW:0] t;
    t = (s >= (PtrW+1)'(BufDepth)) ? s - (PtrW+1)'(BufDepth) : s;
    return t[PtrW-1:0];
  endfunction

  // CRC-8 over one byte, MSB first.
  function automatic logic [7:0] cfp_crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* design/cfp_if.sv */
// ----------------------------------------------------------------------------
// cfp_if
// Valid/ready channels: received bytes in, decoded results out.
// ----------------------------------------------------------------------------
interface cfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfp_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         frame_address;
  logic [3:0]         channel_index;
  logic [10:0]        channel_value;
  logic signed [7:0]  rssi_ant1;
  logic signed [7:0]  rssi_ant2;
  logic [7:0]         link_quality;
  logic signed [7:0]  snr;
  logic [15:0]        voltage_tenths;
  logic [15:0]        current_tenths;
  logic [23:0]        used_capacity;
  logic [7:0]         remaining_percent;

  modport source (output valid, output kind, output frame_address, output channel_index,
                  output channel_value, output rssi_ant1, output rssi_ant2,
                  output link_quality, output snr, output voltage_tenths,
                  output current_tenths, output used_capacity, output remaining_percent,
                  input ready);
  modport sink (input valid, input kind, input frame_address, input channel_index,
                input channel_value, input rssi_ant1, input rssi_ant2,
                input link_quality, input snr, input voltage_tenths,
                input current_tenths, input used_capacity, input remaining_percent,
                output ready);
endinterface

/* design/cfp_ctrl.sv */
// ----------------------------------------------------------------------------
// cfp_ctrl
// Sequencer: append, length check, CRC walk, decode and emit.
// ----------------------------------------------------------------------------
module cfp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_ready,
  input  cfp_pkg::cfp_stat_t stat,
  output cfp_pkg::cfp_cmd_t  cmd
);
  import cfp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_LEN;
    byte_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        byte_ready = 1'b1;
        if (byte_valid) begin
          cmd.append = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_sel = RD_LEN;
        state_next = stat.fill_ge4 ? S_LEN_CHK : S_IDLE;
      end
      S_LEN_CHK: begin
        if (stat.len_bad) begin
          cmd.drop1  = 1'b1;
          state_next = S_SCAN;
        end else if (stat.len_short) begin
          state_next = S_IDLE;
        end else begin
          cmd.len_load = 1'b1;
          cmd.cnt_clr  = 1'b1;
          state_next   = S_CRC_RD;
        end
      end
      S_CRC_RD: begin
        cmd.rd_sel = RD_CRC;
        state_next = S_CRC_ACC;
      end
      S_CRC_ACC: begin
        cmd.crc_acc = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_next  = stat.crc_last ? S_CHK_RD : S_CRC_RD;
      end
      S_CHK_RD: begin
        cmd.rd_sel = RD_CHK;
        state_next = S_CHK_CMP;
      end
      S_CHK_CMP: begin
        if (!stat.crc_ok) begin
          cmd.drop1  = 1'b1;
          state_next = S_SCAN;
        end else begin
          cmd.rd_sel = RD_ADDR;
          state_next = S_ADDR_GET;
        end
      end
      S_ADDR_GET: begin
        cmd.addr_load = 1'b1;
        cmd.rd_sel    = RD_TYPE;
        state_next    = S_TYPE_GET;
      end
      S_TYPE_GET: begin
        cmd.type_load = 1'b1;
        cmd.cnt_clr   = 1'b1;
        state_next    = S_DEC;
      end
      S_DEC: begin
        if (stat.dec == DEC_NONE) begin
          cmd.drop_frame = 1'b1;
          state_next     = S_SCAN;
        end else begin
          state_next = S_PAY_RD;
        end
      end
      S_PAY_RD: begin
        cmd.rd_sel = RD_PAY;
        state_next = S_PAY_GET;
      end
      S_PAY_GET: begin
        cmd.pay_load = 1'b1;
        cmd.cnt_inc  = 1'b1;
        state_next   = S_PAY_NEXT;
      end
      S_PAY_NEXT: begin
        if (stat.dec == DEC_CHAN && stat.ch_avail) begin
          state_next = S_EMIT;
        end else if (stat.pay_done) begin
          if (stat.dec == DEC_CHAN) begin
            cmd.drop_frame = 1'b1;
            state_next     = S_SCAN;
          end else begin
            state_next = S_EMIT;
          end
        end else begin
          state_next = S_PAY_RD;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.dec == DEC_CHAN) begin
            state_next = S_PAY_NEXT;
          end else begin
            cmd.drop_frame = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* design/cfp_dp.sv */
// ----------------------------------------------------------------------------
// cfp_dp
// Circular byte buffer, CRC register, payload unpacker and result register.
// ----------------------------------------------------------------------------
`include "crsf_frame_parser_top_defines.svh"

module cfp_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         rx_byte,
  input  cfp_pkg::cfp_cmd_t  cmd,
  output cfp_pkg::cfp_stat_t stat,
  cfp_res_if.source          res
);
  import cfp_pkg::*;

  logic [7:0]      mem [BufDepth];
  logic [7:0]      rd_data;
  logic [PtrW-1:0] head, head_next;
  logic [PtrW-1:0] fill, fill_next;
  logic [PtrW-1:0] len;
  logic [PtrW-1:0] cnt;
  logic [7:0]      crc;
  logic [7:0]      addr;
  logic [7:0]      ftype;
  logic [7:0]      pay [8];
  logic [17:0]     acc;
  logic [4:0]      nbits;
  logic [3:0]      ch;
  logic [PtrW-1:0] rd_off;
  logic [PtrW-1:0] rd_addr;
  logic [PtrW-1:0] wr_addr;
  logic [PtrW-1:0] need;
  logic [8:0]      flen_raw;
  logic            out_free;
  dec_t            dec;

  always_comb begin
    case (cmd.rd_sel)
      RD_LEN:  rd_off = PtrW'(1);
      RD_CRC:  rd_off = cnt + PtrW'(2);
      RD_CHK:  rd_off = len + PtrW'(1);
      RD_ADDR: rd_off = '0;
      RD_TYPE: rd_off = PtrW'(2);
      RD_PAY:  rd_off = cnt + PtrW'(3);
      default: rd_off = '0;
    endcase
  end

  assign rd_addr = cfp_wrap({1'b0, head} + {1'b0, rd_off});
  assign wr_addr = cfp_wrap({1'b0, head} + {1'b0, fill});

  always_ff @(posedge clk) begin
    if (cmd.append && fill < PtrW'(BufDepth)) begin
      mem[wr_addr] <= rx_byte;
    end
    rd_data <= mem[rd_addr];
  end

  // Head and fill: append, drop one byte, or drop a whole frame.
  always_comb begin
    head_next = head;
    fill_next = fill;
    if (cmd.append) begin
      if (fill < PtrW'(BufDepth)) begin
        fill_next = fill + PtrW'(1);
      end
    end else if (cmd.drop1) begin
      head_next = cfp_wrap({1'b0, head} + (PtrW+1)'(1));
      fill_next = fill - PtrW'(1);
    end else if (cmd.drop_frame) begin
      head_next = cfp_wrap({1'b0, head} + {1'b0, len} + (PtrW+1)'(2));
      fill_next = fill - len - PtrW'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      fill <= fill_next;
    end
  end

  // Frame walk registers.
  always_ff @(posedge clk) begin
    if (cmd.len_load) begin
      len <= rd_data[PtrW-1:0];
      crc <= '0;
    end
    if (cmd.crc_acc) begin
      crc <= cfp_crc_byte(crc, rd_data);
    end
    if (cmd.addr_load) begin
      addr <= rd_data;
    end
    if (cmd.type_load) begin
      ftype <= rd_data;
    end
    if (cmd.cnt_clr) begin
      cnt   <= '0;
      acc   <= '0;
      nbits <= '0;
      ch    <= '0;
    end else begin
      if (cmd.cnt_inc) begin
        cnt <= cnt + PtrW'(1);
      end
      if (cmd.pay_load) begin
        if (cnt < PtrW'(8)) begin
          pay[cnt[2:0]] <= rd_data;
        end
        acc   <= acc | (18'(rd_data) << nbits);
        nbits <= nbits + 5'd8;
      end else if (cmd.emit && (dec == DEC_CHAN)) begin
        acc   <= acc >> 11;
        nbits <= nbits - 5'd11;
        ch    <= ch + 4'd1;
      end
    end
  end

  always_comb begin
    if (ftype == TypeLink && len >= PtrW'(6)) begin
      dec = DEC_LINK;
    end else if (ftype == TypeChannel && len >= PtrW'(24)) begin
      dec = DEC_CHAN;
    end else if (ftype == TypeBattery && len >= PtrW'(10)) begin
      dec = DEC_BATT;
    end else begin
      dec = DEC_NONE;
    end
    case (dec)
      DEC_LINK: need = LinkNeed;
      DEC_CHAN: need = ChanNeed;
      DEC_BATT: need = BattNeed;
      default:  need = '0;
    endcase
  end

  assign flen_raw       = {1'b0, rd_data} + 9'd2;
  assign out_free       = !res.valid || res.ready;
  assign stat.fill_ge4  = fill >= PtrW'(4);
  assign stat.len_bad   = rd_data < 8'd2 || rd_data > 8'(MaxLengthField);
  assign stat.len_short = {2'b00, fill} < flen_raw;
  assign stat.crc_last  = cnt == len - PtrW'(2);
  assign stat.crc_ok    = rd_data == crc;
  assign stat.dec       = dec;
  assign stat.pay_done  = cnt == need;
  assign stat.ch_avail  = nbits >= 5'd11;
  assign stat.out_free  = out_free;

  // Result register: load on emit, hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (cmd.emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res.frame_address     <= addr;
      res.channel_index     <= '0;
      res.channel_value     <= '0;
      res.rssi_ant1         <= '0;
      res.rssi_ant2         <= '0;
      res.link_quality      <= '0;
      res.snr               <= '0;
      res.voltage_tenths    <= '0;
      res.current_tenths    <= '0;
      res.used_capacity     <= '0;
      res.remaining_percent <= '0;
      case (dec)
        DEC_LINK: begin
          res.kind         <= KIND_LINK;
          res.rssi_ant1    <= $signed(pay[0]);
          res.rssi_ant2    <= $signed(pay[1]);
          res.link_quality <= pay[2];
          res.snr          <= $signed(pay[3]);
        end
        DEC_CHAN: begin
          res.kind          <= (ch == 4'd15) ? KIND_CHAN_LAST : KIND_CHAN;
          res.channel_index <= ch;
          res.channel_value <= acc[10:0];
        end
        default: begin
          res.kind              <= KIND_BATT;
          res.voltage_tenths    <= {pay[0], pay[1]};
          res.current_tenths    <= {pay[2], pay[3]};
          res.used_capacity     <= {pay[4], pay[5], pay[6]};
          res.remaining_percent <= pay[7];
        end
      endcase
    end
  end

  `CFP_ASSERT(a_fill_range, fill <= PtrW'(BufDepth), "fill count beyond buffer depth")
  `CFP_ASSERT(a_head_range, head < PtrW'(BufDepth), "head pointer outside buffer")
  `CFP_ASSERT(a_emit_free, !cmd.emit || out_free, "result emitted over an untaken one")
  `CFP_ASSERT_NEXT(a_append_grows, cmd.append, fill == $past(fill) + PtrW'(1), "append lost")

endmodule

/* design/crsf_frame_parser_top.sv */
// Flow: a byte is taken only in the idle state, then the buffer is rescanned; a frame
//   check walks the CRC over its bytes, and then the payload is decoded.
// Input: no new byte is taken while a frame is checked or decoded; the one buffer read
//   port paces the CRC walk, and a bad frame drops one byte and rescans the rest.
// Reset (rst, synchronous): empties the buffer (fill and head to zero) and clears the
//   result valid; buffer contents are left as they are.
// ----------------------------------------------------------------------------
// crsf_frame_parser_top
// Deframer and decoder for a CRC-8 (0xD5) checked serial control link.
// ----------------------------------------------------------------------------
module crsf_frame_parser_top (
  input  logic      clk,
  input  logic      rst,
  cfp_byte_if.sink  rx,
  cfp_res_if.source res
);
  import cfp_pkg::*;

  cfp_cmd_t  cmd;
  cfp_stat_t stat;

  // Sequencer: owns the input handshake, one beat per idle cycle.
  cfp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (rx.valid),
    .byte_ready (rx.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath: buffer, CRC, unpacking; drives the result beat register.
  cfp_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .rx_byte (rx.rx_byte),
    .cmd     (cmd),
    .stat    (stat),
    .res     (res)
  );

endmodule
